@@ hdl/bqi_pkg.sv @@
// Shared types and constants for the byte queue with insert-after.
// Holds command/status codes, cell control codes and the cell control struct.
// No dependencies.
package bqi_pkg;

  localparam int DepthDef = 16;
  localparam int OccW     = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_INSERT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    C_HOLD = 3'd0,
    C_LOAD = 3'd1,
    C_SHL  = 3'd2,
    C_CAPT = 3'd3,
    C_PROP = 3'd4,
    C_INS  = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] value;
    logic [7:0] target;
  } cell_ctrl_t;

endpackage

@@ hdl/bqi_if.sv @@
// Valid/ready channel interfaces for the byte queue: command and result.
// No dependencies.
interface bqi_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] value;
  logic [7:0] target;
  logic [7:0] count;

  modport source (output valid, command, value, target, count, input ready);
  modport sink   (input valid, command, value, target, count, output ready);
endinterface

interface bqi_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] occupancy;
  logic [7:0] head_byte;
  logic       head_valid;

  modport source (output valid, status, occupancy, head_byte, head_valid, input ready);
  modport sink   (input valid, status, occupancy, head_byte, head_valid, output ready);
endinterface

@@ hdl/bqi_cell.sv @@
// One storage cell of the queue chain: a byte, a match flag and a
// "match seen upstream" flag. Depends on bqi_pkg.
module bqi_cell #(
  parameter int DEPTH = bqi_pkg::DepthDef,
  parameter int IDX   = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bqi_pkg::cell_ctrl_t          ctl_i,
  input  logic [$clog2(DEPTH+1)-1:0]   held_i,
  input  logic [7:0]                   left_data_i,
  input  logic                         left_hit_i,
  input  logic                         left_prior_i,
  input  logic [7:0]                   right_data_i,
  output logic [7:0]                   data_o,
  output logic                         hit_o,
  output logic                         prior_o
);
  import bqi_pkg::*;

  localparam int HW = $clog2(DEPTH + 1);

  logic [7:0] data_q, data_d;
  logic       hit_q, hit_d;
  logic       prior_q, prior_d;
  logic       at_tail;
  logic       in_use;

  assign at_tail = (held_i == HW'(IDX));
  assign in_use  = (HW'(IDX) < held_i);

  always_comb begin
    data_d  = data_q;
    hit_d   = hit_q;
    prior_d = prior_q;
    unique case (ctl_i.op)
      C_HOLD: ;
      C_LOAD: begin
        if (at_tail) data_d = ctl_i.value;
      end
      C_SHL: data_d = right_data_i;
      C_CAPT: begin
        hit_d   = in_use && (data_q == ctl_i.target);
        prior_d = 1'b0;
      end
      C_PROP: prior_d = left_prior_i | left_hit_i;
      C_INS: begin
        // first cell past the match takes the new byte, the rest move down
        if (prior_q && !left_prior_i) data_d = ctl_i.value;
        else if (left_prior_i)        data_d = left_data_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      prior_q <= 1'b0;
    end else begin
      hit_q   <= hit_d;
      prior_q <= prior_d;
    end
  end

  assign data_o  = data_q;
  assign hit_o   = hit_q;
  assign prior_o = prior_q;

endmodule

@@ hdl/byte_queue_with_insert_after.sv @@
// Top level of the byte queue with insert-after: sequencer plus cell chain.
// Depends on bqi_pkg, bqi_cmd_if / bqi_res_if and bqi_cell.
//
// Usage:
//   cmd_i carries one command per beat (push, pop count, insert after target);
//   res_o returns exactly one result beat per command: status, occupancy after
//   the command, head byte and head valid. Results come back in command order.
//   The queue is a row of DEPTH cells, head in cell 0, each cell talking only
//   to its neighbors.
// Command handling (command accept to result valid, registered output):
//   - push, status-only commands, pop of 0, 1 or all entries are handled at
//     accept, so one command per cycle when the receiver keeps up.
//   - pop of k entries with 1 < k < occupancy: one shift per cycle along the
//     chain; no new command is taken until the last shift.
//   - insert: capture compares in every cell, the match flag ripples down the
//     chain, then the chain shifts; no new command is taken meanwhile.
// Reset clears the occupancy, so the queue starts empty; cell bytes are not
// cleared and are never read before being written.
// When the receiver stalls, the result beat holds in the output register and
// cmd_i.ready drops until that beat is taken.
module byte_queue_with_insert_after #(
  parameter int DEPTH = bqi_pkg::DepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bqi_cmd_if.sink      cmd_i,
  bqi_res_if.source    res_o
);
  import bqi_pkg::*;

  localparam int HW   = $clog2(DEPTH + 1);
  localparam int CNTW = $clog2(DEPTH);
  localparam int CMPW = (HW > 8) ? HW : 8;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_INS  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [HW-1:0]   held_q, held_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [7:0]      ins_val_q, ins_val_d;

  logic            out_valid_q, out_valid_d;
  status_e         out_status_q;
  logic [OccW-1:0] out_occ_q;
  logic [7:0]      out_head_q;
  logic            out_hv_q;

  cell_ctrl_t      ctl;
  logic [7:0]      data  [DEPTH];
  logic [7:0]      lft_data [DEPTH];
  logic [7:0]      rgt_data [DEPTH];
  logic [DEPTH-1:0] hit, prior, lft_hit, lft_prior;

  logic            acc;
  logic            empty, full, found;
  logic [CMPW-1:0] k_ext, h_ext;
  logic            fin;
  status_e         fin_status;
  logic [7:0]      fin_head;

  // ---------------------------------------------------------------- chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lft_data[g]  = '0;
      assign lft_hit[g]   = 1'b0;
      assign lft_prior[g] = 1'b0;
    end else begin : g_mid
      assign lft_data[g]  = data[g-1];
      assign lft_hit[g]   = hit[g-1];
      assign lft_prior[g] = prior[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rgt_data[g] = '0;
    end else begin : g_notlast
      assign rgt_data[g] = data[g+1];
    end

    bqi_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .held_i       (held_q),
      .left_data_i  (lft_data[g]),
      .left_hit_i   (lft_hit[g]),
      .left_prior_i (lft_prior[g]),
      .right_data_i (rgt_data[g]),
      .data_o       (data[g]),
      .hit_o        (hit[g]),
      .prior_o      (prior[g])
    );
  end

  // ------------------------------------------------------------- handshake
  // Take a command only when idle and the output register is free or draining.
  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || res_o.ready);
  assign acc         = cmd_i.valid && cmd_i.ready;

  assign empty = (held_q == '0);
  assign full  = (held_q == HW'(DEPTH));
  assign k_ext = CMPW'(cmd_i.count);
  assign h_ext = CMPW'(held_q);
  // any match in the chain once the flag has rippled to the last cell
  assign found = prior[DEPTH-1] | hit[DEPTH-1];

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    cnt_d      = cnt_q;
    ins_val_d  = ins_val_q;
    ctl.op     = C_HOLD;
    ctl.value  = (state_q == S_INS) ? ins_val_q : cmd_i.value;
    ctl.target = cmd_i.target;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_head   = empty ? 8'h00 : data[0];

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (cmd_i.command)
            CMD_PUSH: begin
              fin = 1'b1;
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                ctl.op   = C_LOAD;
                held_d   = held_q + HW'(1);
                fin_head = empty ? cmd_i.value : data[0];
              end
            end
            CMD_POP: begin
              if (empty) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else if (k_ext == '0) begin
                fin = 1'b1;
              end else if (k_ext >= h_ext) begin
                // drop everything at once
                fin      = 1'b1;
                held_d   = '0;
                fin_head = 8'h00;
              end else begin
                ctl.op = C_SHL;
                held_d = held_q - HW'(cmd_i.count);
                if (k_ext == CMPW'(1)) begin
                  fin      = 1'b1;
                  fin_head = data[1];
                end else begin
                  cnt_d   = CNTW'(k_ext - CMPW'(1));
                  state_d = S_POP;
                end
              end
            end
            CMD_INSERT: begin
              if (empty) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else if (full) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                ctl.op    = C_CAPT;
                ins_val_d = cmd_i.value;
                cnt_d     = CNTW'(DEPTH - 1);
                state_d   = S_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        // advance the chain by one entry per cycle
        ctl.op = C_SHL;
        if (cnt_q == CNTW'(1)) begin
          fin      = 1'b1;
          fin_head = data[1];
          state_d  = S_IDLE;
        end else begin
          cnt_d = cnt_q - CNTW'(1);
        end
      end
      S_SCAN: begin
        // ripple the match-seen flag one cell further
        ctl.op = C_PROP;
        if (cnt_q == CNTW'(1)) state_d = S_INS;
        else                   cnt_d   = cnt_q - CNTW'(1);
      end
      S_INS: begin
        fin     = 1'b1;
        state_d = S_IDLE;
        if (found) begin
          ctl.op = C_INS;
          held_d = held_q + HW'(1);
        end else begin
          fin_status = ST_NOT_FOUND;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin)              out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload: load only when a command finishes
  always_ff @(posedge clk_i) begin
    ins_val_q <= ins_val_d;
    if (fin) begin
      out_status_q <= fin_status;
      out_occ_q    <= OccW'(held_d);
      out_head_q   <= fin_head;
      out_hv_q     <= (held_d != '0);
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_status_q;
  assign res_o.occupancy  = out_occ_q;
  assign res_o.head_byte  = out_head_q;
  assign res_o.head_valid = out_hv_q;

endmodule

@@ hdl/bqi_checker.sv @@
// Port-level checks for byte_queue_with_insert_after, attached by bind.
// Depends on bqi_pkg and the top level's channel ports.
module bqi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] res_status_i,
  input logic [4:0] res_occ_i,
  input logic [7:0] res_head_i,
  input logic       res_hv_i
);
  import bqi_pkg::*;

  // a stalled result beat holds its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_status_i)
      && $stable(res_occ_i) && $stable(res_head_i) && $stable(res_hv_i))
    else $error("result beat changed while stalled");

  a_occ_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_occ_i != '0) |-> res_hv_i)
    else $error("non-zero occupancy without head valid");

  a_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_hv_i |-> (res_head_i == 8'h00) && (res_occ_i == '0))
    else $error("empty queue reports a head byte or occupancy");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i == ST_EMPTY) |-> !res_hv_i && (res_occ_i == '0))
    else $error("empty status on a non-empty queue");

endmodule

bind byte_queue_with_insert_after bqi_checker u_bqi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status),
  .res_occ_i    (res_o.occupancy),
  .res_head_i   (res_o.head_byte),
  .res_hv_i     (res_o.head_valid)
);
